// ===== design/dbt_pkg.sv =====
// Shared types, constants and character-class helpers for the byte tokenizer.
// No dependencies; every other design file depends on this package.
package dbt_pkg;

  localparam int LINE_WIDTH   = 24;
  localparam int COLUMN_WIDTH = 16;
  localparam int LEN_WIDTH    = 16;
  localparam int KW_COUNT     = 10;
  localparam int KW_CHARS     = 7;

  // Result queue depth; the pointer arithmetic relies on a power of two.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    TT_CREATE  = 5'd0,
    TT_NODE    = 5'd1,
    TT_TASK    = 5'd2,
    TT_AS      = 5'd3,
    TT_CONNECT = 5'd4,
    TT_TO      = 5'd5,
    TT_ON      = 5'd6,
    TT_AFTER   = 5'd7,
    TT_ACTION  = 5'd8,
    TT_SET     = 5'd9,
    TT_IDENT   = 5'd10,
    TT_NUMBER  = 5'd11,
    TT_EQUAL   = 5'd12,
    TT_COMMA   = 5'd13,
    TT_LPAREN  = 5'd14,
    TT_RPAREN  = 5'd15,
    TT_SEMI    = 5'd16,
    TT_UNKNOWN = 5'd17,
    TT_EOF     = 5'd18
  } tok_type_t;

  // Keyword text, right-justified: the last character sits in bits [7:0].
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
    "CREATE", "NODE", "TASK", "AS", "CONNECT", "TO", "ON", "AFTER", "ACTION", "SET"
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd6, 3'd4, 3'd4, 3'd2, 3'd7, 3'd2, 3'd2, 3'd5, 3'd6, 3'd3
  };

  typedef struct packed {
    tok_type_t               token_type;
    logic [LINE_WIDTH-1:0]   token_line;
    logic [COLUMN_WIDTH-1:0] token_column;
    logic [LEN_WIDTH-1:0]    token_length;
    logic [7:0]              token_byte;
    logic                    last_in_run;
  } tok_t;

  // Up to two tokens produced by one accepted input transaction.
  typedef struct packed {
    logic [1:0] count;
    tok_t       rec0;
    tok_t       rec1;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
    logic [2:0] idx;
    idx = KW_LEN[k] - 3'd1 - p;
    return KW_TEXT[k][{idx, 3'b000} +: 8];
  endfunction

  // Drops every keyword no longer than pos or whose character at position pos differs from c.
  function automatic logic [KW_COUNT-1:0] kw_next(input logic [KW_COUNT-1:0] alive,
                                                  input logic [LEN_WIDTH-1:0] pos,
                                                  input logic [7:0] c);
    logic [KW_COUNT-1:0] res;
    for (int i = 0; i < KW_COUNT; i++) begin
      res[i] = alive[i] && (pos < LEN_WIDTH'(KW_LEN[i])) && (kw_char(i, pos[2:0]) == c);
    end
    return res;
  endfunction

  function automatic tok_type_t word_type(input logic [KW_COUNT-1:0] alive,
                                          input logic [LEN_WIDTH-1:0] len);
    tok_type_t t;
    t = TT_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (alive[i] && (len == LEN_WIDTH'(KW_LEN[i]))) t = tok_type_t'(5'(i));
    end
    return t;
  endfunction

endpackage

// ===== design/dbt_stream_if.sv =====
// Valid/ready channel interfaces for the tokenizer's byte input and token output.
// Depends on dbt_pkg for the field widths.
interface dbt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_req;

  modport source(output valid, output kind, output byte_req, input ready);
  modport sink(input valid, input kind, input byte_req, output ready);
endinterface

interface dbt_out_if;
  logic                              valid;
  logic                              ready;
  logic [4:0]                        token_type;
  logic [dbt_pkg::LINE_WIDTH-1:0]    token_line;
  logic [dbt_pkg::COLUMN_WIDTH-1:0]  token_column;
  logic [dbt_pkg::LEN_WIDTH-1:0]     token_length;
  logic [7:0]                        token_byte;
  logic                              last_in_run;

  modport source(output valid, output token_type, output token_line, output token_column,
                 output token_length, output token_byte, output last_in_run, input ready);
  modport sink(input valid, input token_type, input token_line, input token_column,
               input token_length, input token_byte, input last_in_run, output ready);
endinterface

// ===== design/dsl_byte_tokenizer.sv =====
// Top level of the byte tokenizer: scanner core feeding a token queue.
// Depends on dbt_pkg, dbt_stream_if, dbt_scan_core and dbt_out_queue.
//
// Usage: source bytes enter on in_ch, one per transaction, with kind low; a
// transaction with kind high marks end of file. Each input transaction gives
// zero, one or two tokens on out_ch, one token per transaction, and the last
// token caused by an input transaction carries last_in_run. The block keeps
// line and column counters, the open word or number and a keyword match
// vector, so keywords are recognized while the word streams in.
// With no older token waiting in the queue, a token is offered on out_ch
// in the cycle after the input transaction that causes it. Throughput: one
// byte per cycle while in_ch.ready is high; a byte that closes a token and
// makes a punctuation token produces two tokens, which drain at one per
// cycle while the receiver is ready.
// in_ch.ready is high while the four-entry token queue has room for two
// tokens, so a stalled receiver lets the block keep taking bytes until the
// queue fills, then holds in_ch off; no token is dropped or duplicated.
// Reset (rst_n low at a clock edge) empties the queue and returns the
// scanner to line 1, column 1, with no open token. End of file also
// returns the scanner to that state, so the next byte starts a new stream.
module dsl_byte_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  dbt_in_if.sink    in_ch,
  dbt_out_if.source out_ch
);
  import dbt_pkg::*;

  logic  acc;
  logic  space;
  push_t push;

  // The queue's free space alone decides ready; the scanner never stalls.
  assign in_ch.ready = space;
  assign acc         = in_ch.valid && in_ch.ready;

  dbt_scan_core u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .kind     (in_ch.kind),
    .byte_req (in_ch.byte_req),
    .push     (push)
  );

  dbt_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .space  (space),
    .out_ch (out_ch)
  );

  // Tokens are only produced by an accepted input transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    !acc |-> push.count == 2'd0)
    else $error("token pushed without an input transaction");

  // An end-of-file token is always empty and always ends its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.token_type == 5'(TT_EOF))
      |-> (out_ch.token_length == '0 && out_ch.last_in_run))
    else $error("malformed end-of-file token");

  // An end-of-file transaction always yields at least one token next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.kind) |=> out_ch.valid)
    else $error("end of file produced no token");

endmodule

// ===== design/dbt_scan_core.sv =====
// Scanner state (mode, line, column, open token) and the combinational next-state logic.
// Depends on dbt_pkg; emits up to two tokens per accepted input transaction as a push_t.
module dbt_scan_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic           kind,
  input  logic [7:0]     byte_req,
  output dbt_pkg::push_t push
);
  import dbt_pkg::*;

  mode_t                   mode_r, mode_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;
  logic [COLUMN_WIDTH-1:0] col_r, col_nxt;
  logic [COLUMN_WIDTH-1:0] start_r, start_nxt;
  logic [LEN_WIDTH-1:0]    len_r, len_nxt;
  logic [KW_COUNT-1:0]     alive_r, alive_nxt;

  logic [COLUMN_WIDTH-1:0] col_inc;
  logic [LINE_WIDTH-1:0]   line_inc;
  logic [LEN_WIDTH-1:0]    len_inc;
  tok_t                    close_rec;
  tok_t                    one_rec;
  tok_type_t               punct_type;

  assign col_inc  = (col_r == '1) ? col_r : col_r + 1'b1;
  assign line_inc = (line_r == '1) ? line_r : line_r + 1'b1;
  assign len_inc  = (len_r == '1) ? len_r : len_r + 1'b1;

  always_comb begin
    unique case (byte_req)
      CH_EQUAL:  punct_type = TT_EQUAL;
      CH_COMMA:  punct_type = TT_COMMA;
      CH_LPAREN: punct_type = TT_LPAREN;
      CH_RPAREN: punct_type = TT_RPAREN;
      CH_SEMI:   punct_type = TT_SEMI;
      default:   punct_type = TT_UNKNOWN;
    endcase
  end

  always_comb begin
    close_rec.token_type   = (mode_r == MODE_WORD) ? word_type(alive_r, len_r) : TT_NUMBER;
    close_rec.token_line   = line_r;
    close_rec.token_column = start_r;
    close_rec.token_length = len_r;
    close_rec.token_byte   = '0;
    close_rec.last_in_run  = 1'b0;
  end

  always_comb begin
    logic do_close;
    logic do_idle;
    logic open_tok;
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    alive_nxt = alive_r;
    one_rec   = close_rec;
    push      = '0;
    do_close  = 1'b0;
    do_idle   = 1'b0;
    open_tok  = (mode_r == MODE_WORD) || (mode_r == MODE_NUMBER);

    if (acc && kind) begin
      // End of file flushes the open token, reports the end and restarts the stream.
      one_rec.token_type   = TT_EOF;
      one_rec.token_line   = line_r;
      one_rec.token_column = col_r;
      one_rec.token_length = '0;
      one_rec.token_byte   = '0;
      if (open_tok) begin
        push.rec0  = close_rec;
        push.rec1  = one_rec;
        push.count = 2'd2;
      end else begin
        push.rec0  = one_rec;
        push.count = 2'd1;
      end
      mode_nxt  = MODE_IDLE;
      line_nxt  = LINE_WIDTH'(1);
      col_nxt   = COLUMN_WIDTH'(1);
      start_nxt = '0;
      len_nxt   = '0;
      alive_nxt = '0;
    end else if (acc) begin
      case (mode_r)
        MODE_COMMENT: begin
          if (byte_req == CH_LF) do_idle = 1'b1;
        end
        MODE_WORD: begin
          if (is_word(byte_req)) begin
            alive_nxt = kw_next(alive_r, len_r, byte_req);
            len_nxt   = len_inc;
            col_nxt   = col_inc;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(byte_req)) begin
            len_nxt = len_inc;
            col_nxt = col_inc;
          end else begin
            do_close = 1'b1;
            do_idle  = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_nxt  = MODE_IDLE;
        start_nxt = '0;
        len_nxt   = '0;
        alive_nxt = '0;
        if (do_close) begin
          push.rec0  = close_rec;
          push.count = 2'd1;
        end
        if (is_space(byte_req)) begin
          if (byte_req == CH_LF) begin
            line_nxt = line_inc;
            col_nxt  = COLUMN_WIDTH'(1);
          end else begin
            col_nxt = col_inc;
          end
        end else if (byte_req == CH_HASH) begin
          mode_nxt = MODE_COMMENT;
        end else if (is_word(byte_req)) begin
          mode_nxt  = is_digit(byte_req) ? MODE_NUMBER : MODE_WORD;
          start_nxt = col_r;
          len_nxt   = LEN_WIDTH'(1);
          alive_nxt = is_digit(byte_req) ? '0 : kw_next('1, '0, byte_req);
          col_nxt   = col_inc;
        end else begin
          one_rec.token_type   = punct_type;
          one_rec.token_line   = line_r;
          one_rec.token_column = col_r;
          one_rec.token_length = LEN_WIDTH'(1);
          one_rec.token_byte   = byte_req;
          col_nxt              = col_inc;
          if (do_close) begin
            push.rec1  = one_rec;
            push.count = 2'd2;
          end else begin
            push.rec0  = one_rec;
            push.count = 2'd1;
          end
        end
      end
    end

    if (push.count == 2'd2) push.rec1.last_in_run = 1'b1;
    if (push.count == 2'd1) push.rec0.last_in_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      line_r  <= LINE_WIDTH'(1);
      col_r   <= COLUMN_WIDTH'(1);
      start_r <= '0;
      len_r   <= '0;
      alive_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      alive_r <= alive_nxt;
    end
  end

endmodule

// ===== design/dbt_out_queue.sv =====
// Small token queue: takes up to two tokens per cycle, presents one per transaction.
// Depends on dbt_pkg and the dbt_out_if interface.
module dbt_out_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  dbt_pkg::push_t push,
  output logic           space,
  dbt_out_if.source      out_ch
);
  import dbt_pkg::*;

  tok_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wr_ptr_p1;
  tok_t              head;

  // Room for a worst-case pair of tokens, without counting on a pop this cycle.
  assign space     = (count_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push.count) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem_r[wr_ptr_r] <= push.rec0;
    if (push.count == 2'd2) mem_r[wr_ptr_p1] <= push.rec1;
  end

  assign out_ch.valid        = (count_r != '0);
  assign out_ch.token_type   = head.token_type;
  assign out_ch.token_line   = head.token_line;
  assign out_ch.token_column = head.token_column;
  assign out_ch.token_length = head.token_length;
  assign out_ch.token_byte   = head.token_byte;
  assign out_ch.last_in_run  = head.last_in_run;

endmodule

// ===== sim/dsl_byte_tokenizer_checker.sv =====
// Scoreboard for the byte tokenizer: watches both channels, predicts tokens, compares them.
// Depends on dbt_pkg for the token record and codes, and on dbt_stream_if for the channels.
module dsl_byte_tokenizer_checker (
  input  logic clk,
  input  logic rst_n,
  dbt_in_if    in_mon,
  dbt_out_if   out_mon,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dbt_pkg::*;

  mode_t                   lex_mode;
  logic [LINE_WIDTH-1:0]   cur_line;
  logic [COLUMN_WIDTH-1:0] cur_col;
  logic [COLUMN_WIDTH-1:0] tok_start;
  logic [LEN_WIDTH-1:0]    tok_len;
  // The last eight characters of the open word, newest in the low byte.
  logic [63:0]             word_bits;
  tok_t                    tokens_due[$];
  int                      fail_count = 0;

  assign mismatches = fail_count;

  function automatic logic blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic word_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || digit_char(c) || c == CH_UNDER;
  endfunction

  // A keyword is recognized from the whole word text once the word closes.
  function automatic tok_type_t classify_word(input logic [63:0] w, input logic [LEN_WIDTH-1:0] n);
    if (n > 7) return TT_IDENT;
    case (w)
      "CREATE":  return TT_CREATE;
      "NODE":    return TT_NODE;
      "TASK":    return TT_TASK;
      "AS":      return TT_AS;
      "CONNECT": return TT_CONNECT;
      "TO":      return TT_TO;
      "ON":      return TT_ON;
      "AFTER":   return TT_AFTER;
      "ACTION":  return TT_ACTION;
      "SET":     return TT_SET;
      default:   return TT_IDENT;
    endcase
  endfunction

  function automatic void lex_restart();
    lex_mode  = MODE_IDLE;
    cur_line  = 1;
    cur_col   = 1;
    tok_start = 0;
    tok_len   = 0;
    word_bits = 0;
  endfunction

  function automatic void bump_col();
    if (cur_col != '1) cur_col++;
  endfunction

  function automatic void emit_token(input tok_type_t tt, input logic [COLUMN_WIDTH-1:0] col,
                                     input logic [LEN_WIDTH-1:0] len, input logic [7:0] ch);
    tok_t t;
    t.token_type   = tt;
    t.token_line   = cur_line;
    t.token_column = col;
    t.token_length = len;
    t.token_byte   = ch;
    t.last_in_run  = 1'b0;
    tokens_due.insert(tokens_due.size(), t);
  endfunction

  function automatic void grow(input logic [7:0] c);
    word_bits = {word_bits[55:0], c};
    if (tok_len != '1) tok_len++;
    bump_col();
  endfunction

  function automatic void close_token();
    tok_type_t tt;
    tt = (lex_mode == MODE_WORD) ? classify_word(word_bits, tok_len) : TT_NUMBER;
    emit_token(tt, tok_start, tok_len, 8'h00);
    lex_mode  = MODE_IDLE;
    tok_start = 0;
    tok_len   = 0;
  endfunction

  function automatic void from_idle(input logic [7:0] c);
    tok_type_t pt;
    if (blank_char(c)) begin
      if (c == CH_LF) begin
        if (cur_line != '1) cur_line++;
        cur_col = 1;
      end else begin
        bump_col();
      end
    end else if (c == CH_HASH) begin
      lex_mode = MODE_COMMENT;
    end else if (word_char(c)) begin
      lex_mode  = digit_char(c) ? MODE_NUMBER : MODE_WORD;
      tok_start = cur_col;
      tok_len   = 0;
      word_bits = 0;
      grow(c);
    end else begin
      case (c)
        CH_EQUAL:  pt = TT_EQUAL;
        CH_COMMA:  pt = TT_COMMA;
        CH_LPAREN: pt = TT_LPAREN;
        CH_RPAREN: pt = TT_RPAREN;
        CH_SEMI:   pt = TT_SEMI;
        default:   pt = TT_UNKNOWN;
      endcase
      emit_token(pt, cur_col, LEN_WIDTH'(1), c);
      bump_col();
    end
  endfunction

  function automatic void lex_step(input logic eof, input logic [7:0] c);
    int n0;
    n0 = tokens_due.size();
    if (eof) begin
      if (lex_mode == MODE_WORD || lex_mode == MODE_NUMBER) close_token();
      emit_token(TT_EOF, cur_col, LEN_WIDTH'(0), 8'h00);
      lex_restart();
    end else begin
      case (lex_mode)
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            lex_mode = MODE_IDLE;
            from_idle(c);
          end
        end
        MODE_WORD: begin
          if (word_char(c)) begin
            grow(c);
          end else begin
            close_token();
            from_idle(c);
          end
        end
        MODE_NUMBER: begin
          if (digit_char(c)) begin
            grow(c);
          end else begin
            close_token();
            from_idle(c);
          end
        end
        default: from_idle(c);
      endcase
    end
    if (tokens_due.size() > n0) tokens_due[tokens_due.size() - 1].last_in_run = 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    tok_t due;
    if (!rst_n) begin
      tokens_due.delete();
      lex_restart();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (tokens_due.size() == 0) begin
          $display("%0t: unexpected token, expected none, actual type %0d line %0d column %0d",
                   $time, out_mon.token_type, out_mon.token_line, out_mon.token_column);
          fail_count++;
        end else begin
          due = tokens_due.pop_front();
          compare_field("type", due.token_type, out_mon.token_type);
          compare_field("line", due.token_line, out_mon.token_line);
          compare_field("column", due.token_column, out_mon.token_column);
          compare_field("length", due.token_length, out_mon.token_length);
          compare_field("byte", due.token_byte, out_mon.token_byte);
          compare_field("last_in_run", due.last_in_run, out_mon.last_in_run);
        end
      end
      if (in_mon.valid && in_mon.ready) lex_step(in_mon.kind, in_mon.byte_req);
    end
    outstanding <= tokens_due.size();
  end

endmodule

// ===== sim/dsl_byte_tokenizer_tb.sv =====
// Top of the byte tokenizer testbench: clock, reset, byte stimulus, token drain, verdict.
// Depends on dbt_pkg, dbt_stream_if, dsl_byte_tokenizer and dsl_byte_tokenizer_checker.
module dsl_byte_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dbt_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Cycles with no transaction on either channel before the run is declared hung.
  // The longest legal quiet stretch is the long receiver hold below.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_TAIL     = 16;
  // One word far longer than any keyword, so it must come out as an identifier.
  localparam int LONG_WORD      = 24;

  logic clk;
  logic rst_n;

  dbt_in_if  in_ch ();
  dbt_out_if out_ch ();

  dsl_byte_tokenizer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int mismatches;
  int outstanding;

  dsl_byte_tokenizer_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Shared between the byte sender and the token receiver. The sender raises
  // rx_hold_req to ask the receiver for one long stall while bytes keep coming.
  bit tx_calm;
  bit rx_calm;
  bit rx_hold_req;
  int items_sent;

  // Pending input transactions: bit 8 is the end-of-file kind, bits 7:0 the byte.
  logic [8:0] script[$];

  // ---------------------------------------------------------------------------
  // Watchdog: any transaction on either channel restarts the count. A hang,
  // a lost token or a stuck ready all end up here.
  // ---------------------------------------------------------------------------
  int quiet;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles, %0d tokens still expected",
               $time, quiet, outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Token receiver. Before each token it may hold ready low for a random wait,
  // except in calm stretches where it takes every token at once. Ready is
  // lowered only when a wait is actually drawn, so a ready that stays high is
  // never dropped and raised in the same time step.
  // ---------------------------------------------------------------------------
  initial begin : token_drain
    int gap;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold_req) begin
        // Long stall: the four-entry token queue fills and the block must
        // push back on its byte input until this side resumes.
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken % 32 == 0) rx_calm = ($urandom_range(0, 2) == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender helpers.
  // ---------------------------------------------------------------------------

  // One input transaction. Valid stays high from one item to the next when no
  // gap is drawn; the data changes at the edge that accepted the previous one.
  task automatic send_item(input logic eof, input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= eof;
    in_ch.byte_req <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (items_sent % 48 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_script();
    logic [8:0] it;
    while (script.size() != 0) begin
      it = script.pop_front();
      send_item(it[8], it[7:0]);
    end
  endtask

  // Input goes quiet until every predicted token has been taken. The
  // scoreboard's count is registered, which already covers the last byte.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    script.insert(script.size(), {1'b0, b});
  endtask

  task automatic queue_eof();
    // The byte field carries noise here; the block must ignore it.
    script.insert(script.size(), {1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic string keyword_text(input int idx);
    case (idx)
      0:       return "CREATE";
      1:       return "NODE";
      2:       return "TASK";
      3:       return "AS";
      4:       return "CONNECT";
      5:       return "TO";
      6:       return "ON";
      7:       return "AFTER";
      8:       return "ACTION";
      default: return "SET";
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 3) == 0) ? "a" + c : "A" + c;
  endfunction

  function automatic logic [7:0] rand_word_char();
    case ($urandom_range(0, 5))
      0:       return "0" + 8'($urandom_range(0, 9));
      1:       return CH_UNDER;
      default: return rand_letter();
    endcase
  endfunction

  function automatic logic [7:0] rand_punct();
    case ($urandom_range(0, 4))
      0:       return CH_EQUAL;
      1:       return CH_COMMA;
      2:       return CH_LPAREN;
      3:       return CH_RPAREN;
      default: return CH_SEMI;
    endcase
  endfunction

  // One lexical fragment of a plausible command line, now and then followed
  // by a separator. Most fragments are well formed; near-keywords, comments
  // full of arbitrary bytes and raw noise bytes make up the rest.
  task automatic queue_fragment();
    string kw;
    int    n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: queue_text(keyword_text($urandom_range(0, 9)));
      5: begin
        // Near miss: a keyword cut short, extended, or with its tail altered.
        kw = keyword_text($urandom_range(0, 9));
        case ($urandom_range(0, 2))
          0: for (int i = 0; i < kw.len() - 1; i++) queue_byte(kw[i]);
          1: begin
            queue_text(kw);
            queue_byte(rand_word_char());
          end
          default: begin
            for (int i = 0; i < kw.len() - 1; i++) queue_byte(kw[i]);
            queue_byte(rand_letter());
          end
        endcase
      end
      6, 7, 8: begin
        queue_byte(($urandom_range(0, 4) == 0) ? CH_UNDER : rand_letter());
        n = $urandom_range(0, 9);
        repeat (n) queue_byte(rand_word_char());
      end
      9, 10: begin
        n = $urandom_range(1, 6);
        repeat (n) queue_byte("0" + 8'($urandom_range(0, 9)));
      end
      11, 12, 13: queue_byte(rand_punct());
      14, 15: begin
        case ($urandom_range(0, 5))
          0:       queue_byte(CH_TAB);
          1:       queue_byte(CH_VT);
          2:       queue_byte(CH_FF);
          3:       queue_byte(CH_CR);
          default: queue_byte(CH_SPACE);
        endcase
      end
      16: begin
        // Comment body holds odd bytes only, so never a newline; the newline ends it
        // most of the time, otherwise an end of file cuts the comment off.
        queue_byte(CH_HASH);
        n = $urandom_range(0, 8);
        repeat (n) queue_byte(8'($urandom_range(0, 255)) | 8'h01 ^ (CH_LF == 8'h0B));
        if ($urandom_range(0, 5) == 0) queue_eof();
        else queue_byte(CH_LF);
      end
      17: queue_byte(8'($urandom_range(0, 255)));
      18: queue_byte(CH_LF);
      default: begin
        if ($urandom_range(0, 2) == 0) queue_eof();
        else queue_byte(CH_SPACE);
      end
    endcase
    // Separators are usual but not guaranteed, so tokens also abut.
    if ($urandom_range(0, 2) != 0) queue_byte(($urandom_range(0, 7) == 0) ? CH_LF : CH_SPACE);
  endtask

  task automatic run_random(input int count);
    int stop_at;
    int hold_at;
    stop_at = items_sent + count;
    hold_at = items_sent + count / 3;
    while (items_sent < stop_at) begin
      if (hold_at != 0 && items_sent >= hold_at) begin
        rx_hold_req = 1'b1;
        hold_at     = 0;
      end
      queue_fragment();
      send_script();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= 1'b0;
    in_ch.byte_req <= 8'h00;
    rst_n          <= 1'b0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    rx_hold_req = 1'b0;
    items_sent  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: a keyword closed by punctuation (two tokens from one
    // byte), a number closed by a letter, a one-letter word, every punctuation
    // mark, an underscore identifier, a tab, a comment whose newline ends it
    // with the column frozen inside, unknown bytes at both ends of the range,
    // the remaining whitespace bytes, and end of file with a number and then
    // a word still open.
    queue_text("TO=42a,(_);");
    queue_byte(CH_TAB);
    queue_byte(CH_HASH);
    queue_byte("z");
    queue_byte(CH_LF);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CH_VT);
    queue_byte(CH_FF);
    queue_byte(CH_CR);
    queue_byte("5");
    queue_eof();
    queue_byte("Q");
    queue_eof();
    send_script();

    // The sender waits for every token before going on.
    wait_drained();

    run_random(300);
    wait_drained();

    // A fresh stream with one word far longer than any keyword, closed by
    // punctuation, then a short word and a newline. Sent back to back.
    tx_calm = 1'b1;
    send_item(1'b1, 8'h00);
    send_item(1'b0, "w");
    for (int i = 1; i < LONG_WORD; i++) send_item(1'b0, rand_word_char());
    send_item(1'b0, CH_SEMI);
    send_item(1'b0, "a");
    send_item(1'b0, "b");
    send_item(1'b0, CH_LF);
    send_item(1'b1, 8'h00);
    tx_calm = 1'b0;

    run_random(300);
    queue_eof();
    send_script();

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dbt_pkg.sv
design/dbt_stream_if.sv
design/dbt_scan_core.sv
design/dbt_out_queue.sv
design/dsl_byte_tokenizer.sv
sim/dsl_byte_tokenizer_checker.sv
sim/dsl_byte_tokenizer_tb.sv
